// ----- rtl/rgbrl_pkg.sv -----
// Shared types and constants for the RGB run-length pixel decoder.
// No dependencies; imported by every module of the block.
package rgbrl_pkg;

	localparam int FP_W                 = 23;
	localparam int MAX_FRAME_PIXELS_DEF = 4194304;
	localparam logic [FP_W-1:0] FRAME_PIXELS_RST = FP_W'(307200);

	localparam logic [7:0]  COUNT_EXT_BIT  = 8'h80;
	localparam logic [7:0]  COUNT_LOW_MASK = 8'h7F;
	localparam logic [14:0] COUNT_ESCAPE   = 15'h7FFF;
	localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;

	// Byte position inside a pixel
	localparam logic [1:0] BP_RED   = 2'd0;
	localparam logic [1:0] BP_GREEN = 2'd1;
	localparam logic [1:0] BP_BLUE  = 2'd2;

	// Count reader position
	localparam logic [2:0] CP_NONE   = 3'd0;
	localparam logic [2:0] CP_FIRST  = 3'd1;
	localparam logic [2:0] CP_SECOND = 3'd2;
	localparam logic [2:0] CP_WORD0  = 3'd3;
	localparam logic [2:0] CP_WORD1  = 3'd4;
	localparam logic [2:0] CP_WORD2  = 3'd5;
	localparam logic [2:0] CP_WORD3  = 3'd6;

	typedef struct packed {
		logic [7:0]      red;
		logic [7:0]      green;
		logic [7:0]      blue;
		logic [FP_W-1:0] run_length;
		logic            frame_done;
		logic            incomplete;
	} rgbrl_result_t;

endpackage

// ----- rtl/rgbrl_decode.sv -----
// Decode state and per-byte step logic: pixel assembly, count reading, run clipping.
// Depends on rgbrl_pkg.
module rgbrl_decode #(
	parameter int MAX_FRAME_PIXELS = rgbrl_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [7:0]                  data_byte,
	input  logic                        frame_end,
	input  logic [rgbrl_pkg::FP_W-1:0]  frame_pixels,
	output logic                        res_valid,
	output rgbrl_pkg::rgbrl_result_t    res
);
	import rgbrl_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_PIXELS + 1);
	localparam logic [31:0] MAX32 = 32'(MAX_FRAME_PIXELS);

	logic [1:0]    byte_phase_q, byte_phase_d;
	logic [15:0]   held_q, held_d;
	logic [23:0]   prev_color_q, prev_color_d;
	logic          prev_valid_q, prev_valid_d;
	logic [2:0]    count_phase_q, count_phase_d;
	logic [31:0]   count_value_q, count_value_d;
	logic [PW-1:0] emitted_q, emitted_d;

	logic [31:0] fp32, limit, emitted32, left;
	logic [31:0] cnt, run, new_emitted, word_or;
	logic        fin, rec;
	logic [23:0] rec_color;
	logic [31:0] rec_run;
	logic [23:0] color;
	logic [14:0] v15;

	always_comb begin
		fp32      = {{(32-FP_W){1'b0}}, frame_pixels};
		limit     = (fp32 > MAX32) ? MAX32 : fp32;
		emitted32 = 32'(emitted_q);
		left      = (emitted32 >= limit) ? 32'd0 : limit - emitted32;

		byte_phase_d  = byte_phase_q;
		held_d        = held_q;
		prev_color_d  = prev_color_q;
		prev_valid_d  = prev_valid_q;
		count_phase_d = count_phase_q;
		count_value_d = count_value_q;
		new_emitted   = emitted32;

		fin       = 1'b0;
		cnt       = 32'd0;
		rec       = 1'b0;
		rec_color = 24'd0;
		rec_run   = 32'd0;
		run       = 32'd0;
		color     = {data_byte, held_q};
		v15       = {count_value_q[6:0], data_byte};
		word_or   = count_value_q;

		if (left == 32'd0) begin
			// frame full: drop the byte
			byte_phase_d  = BP_RED;
			count_phase_d = CP_NONE;
			count_value_d = 32'd0;
		end else begin
			case (count_phase_q)
				CP_FIRST: begin
					if ((data_byte & COUNT_EXT_BIT) != 8'd0) begin
						count_value_d = {24'd0, data_byte & COUNT_LOW_MASK};
						count_phase_d = CP_SECOND;
					end else begin
						fin = 1'b1;
						cnt = {24'd0, data_byte};
					end
				end
				CP_SECOND: begin
					if (v15 == COUNT_ESCAPE) begin
						count_value_d = 32'd0;
						count_phase_d = CP_WORD0;
					end else begin
						fin = 1'b1;
						cnt = {17'd0, v15};
					end
				end
				CP_WORD0: begin
					count_value_d = count_value_q | {24'd0, data_byte};
					count_phase_d = CP_WORD1;
				end
				CP_WORD1: begin
					count_value_d = count_value_q | {16'd0, data_byte, 8'd0};
					count_phase_d = CP_WORD2;
				end
				CP_WORD2: begin
					count_value_d = count_value_q | {8'd0, data_byte, 16'd0};
					count_phase_d = CP_WORD3;
				end
				CP_WORD3: begin
					word_or = (count_value_q | {data_byte, 24'd0}) & COUNT_MAX;
					fin     = 1'b1;
					cnt     = word_or;
				end
				default: begin
					count_phase_d = CP_NONE;
					case (byte_phase_q)
						BP_RED: begin
							held_d       = {8'd0, data_byte};
							byte_phase_d = BP_GREEN;
						end
						BP_GREEN: begin
							held_d       = {data_byte, held_q[7:0]};
							byte_phase_d = BP_BLUE;
						end
						default: begin
							byte_phase_d = BP_RED;
							held_d       = 16'd0;
							new_emitted  = emitted32 + 32'd1;
							rec          = 1'b1;
							rec_color    = color;
							rec_run      = 32'd1;
							// repeated color opens a count unless the pixel fills the frame
							if (prev_valid_q && (color == prev_color_q) && (left > 32'd1)) begin
								count_phase_d = CP_FIRST;
								count_value_d = 32'd0;
							end
							prev_color_d = color;
							prev_valid_d = 1'b1;
						end
					endcase
				end
			endcase

			if (fin) begin
				count_phase_d = CP_NONE;
				count_value_d = 32'd0;
				if (cnt > 32'd2) begin
					run = cnt - 32'd2;
					if (run > left)
						run = left;
					if (run != 32'd0) begin
						new_emitted = emitted32 + run;
						rec         = 1'b1;
						rec_color   = prev_color_q;
						rec_run     = run;
					end
				end
			end
		end

		emitted_d = new_emitted[PW-1:0];

		res_valid      = rec || frame_end;
		res.red        = rec_color[7:0];
		res.green      = rec_color[15:8];
		res.blue       = rec_color[23:16];
		res.run_length = rec_run[FP_W-1:0];
		res.frame_done = frame_end;
		res.incomplete = frame_end &&
			((byte_phase_d != BP_RED) || (count_phase_d != CP_NONE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q  <= BP_RED;
			held_q        <= 16'd0;
			prev_color_q  <= 24'd0;
			prev_valid_q  <= 1'b0;
			count_phase_q <= CP_NONE;
			count_value_q <= 32'd0;
			emitted_q     <= '0;
		end else if (go) begin
			if (frame_end) begin
				byte_phase_q  <= BP_RED;
				held_q        <= 16'd0;
				prev_color_q  <= 24'd0;
				prev_valid_q  <= 1'b0;
				count_phase_q <= CP_NONE;
				count_value_q <= 32'd0;
				emitted_q     <= '0;
			end else begin
				byte_phase_q  <= byte_phase_d;
				held_q        <= held_d;
				prev_color_q  <= prev_color_d;
				prev_valid_q  <= prev_valid_d;
				count_phase_q <= count_phase_d;
				count_value_q <= count_value_d;
				emitted_q     <= emitted_d;
			end
		end
	end

endmodule

// ----- rtl/rgbrl_out_queue.sv -----
// Two-entry result register with skid slot in front of the output channel.
// Depends on rgbrl_pkg.
module rgbrl_out_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  rgbrl_pkg::rgbrl_result_t push_data,
	output logic                     full,
	output logic                     out_valid,
	input  logic                     out_stall,
	output rgbrl_pkg::rgbrl_result_t head
);
	import rgbrl_pkg::*;

	rgbrl_result_t slot0_q, slot1_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign head      = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot0_q <= (push && (cnt_q == 2'd1)) ? push_data : slot1_q;
			if (push && (cnt_q == 2'd2))
				slot1_q <= push_data;
		end else if (push) begin
			if (cnt_q == 2'd0)
				slot0_q <= push_data;
			else
				slot1_q <= push_data;
		end
	end

endmodule

// ----- rtl/rgb_run_length_pixel_decoder_core.sv -----
// Top level of the RGB run-length pixel decoder: input register, decode, result queue.
// Depends on rgbrl_pkg, rgbrl_decode and rgbrl_out_queue.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  data_byte, frame_end
// result    out        out_valid/out_stall  red, green, blue, run_length, frame_done, incomplete
// config    in         cfg_we               cfg_wdata (frame_pixels)
//
// One byte per cycle sustained while in_stall stays low. A taken byte sits in the input register,
// where one pass of compare, shift and subtract decodes it; its result, if any, is registered
// into the result queue once the queue has room, and is offered on the result channel from there.
// Reset clears all decode state and sets frame_pixels to 307200.
// With the output stalled, in_stall rises only once both result slots are held and
// drops after the edge at which the head transaction is taken.
module rgb_run_length_pixel_decoder_core #(
	parameter int MAX_FRAME_PIXELS = rgbrl_pkg::MAX_FRAME_PIXELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rgbrl_pkg::FP_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       frame_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue,
	output logic [rgbrl_pkg::FP_W-1:0] run_length,
	output logic                       frame_done,
	output logic                       incomplete
);
	import rgbrl_pkg::*;

	logic [FP_W-1:0] frame_pixels_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;
	logic            full;
	logic            go;
	logic            res_valid;
	rgbrl_result_t   res;
	rgbrl_result_t   head;

	// Advance the input register when the result queue has room for its outcome.
	assign go       = valid_s1 && !full;
	assign in_stall = valid_s1 && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_we) begin
			frame_pixels_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload while stalled; capture on each accepted transaction.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	rgbrl_decode #(
		.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
	) u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.data_byte    (byte_s1),
		.frame_end    (end_s1),
		.frame_pixels (frame_pixels_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	rgbrl_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go && res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign red        = head.red;
	assign green      = head.green;
	assign blue       = head.blue;
	assign run_length = head.run_length;
	assign frame_done = head.frame_done;
	assign incomplete = head.incomplete;

endmodule

// ----- test/tb_rgb_run_length_pixel_decoder_core.sv -----
// Self-checking testbench for rgb_run_length_pixel_decoder_core: directed table, then random
// frames of pixels and run counts, scored by table answers or a cycle-free decoder model.
// Depends on rgbrl_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_rgb_run_length_pixel_decoder_core;
	import rgbrl_pkg::*;

	localparam logic [FP_W-1:0] MAX_PIX = FP_W'(MAX_FRAME_PIXELS_DEF);
	localparam int SETTLE_CYCLES  = 4;     // pipeline is two deep; allow a little extra
	localparam int HOLD_CYCLES    = 80;    // long output hold-off, enough to back up the input
	localparam int STUCK_LIMIT    = 3000;  // cycles with no transaction on either side
	localparam int TARGET_BYTES   = 950;   // bytes taken before the random part stops

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t       kind;
		logic [FP_W-1:0] setting;
		logic [7:0]      data;
		logic            last;
		bit              typed;
		rgbrl_result_t   answer;
	} table_row_t;

	// Answer spelled out by the directed table for one byte in flight, if any
	typedef struct {
		bit            typed;
		rgbrl_result_t answer;
	} byte_answer_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [FP_W-1:0] cfg_wdata;
	logic            in_valid;
	logic            in_stall;
	logic [7:0]      data_byte;
	logic            frame_end;
	logic            out_valid;
	logic            out_stall;
	logic [7:0]      red;
	logic [7:0]      green;
	logic [7:0]      blue;
	logic [FP_W-1:0] run_length;
	logic            frame_done;
	logic            incomplete;

	rgb_run_length_pixel_decoder_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.run_length (run_length),
		.frame_done (frame_done),
		.incomplete (incomplete)
	);

	// Decoder model state: one copy of the frame size register and the per-frame registers
	logic [FP_W-1:0] fp_reg;
	logic [1:0]      pix_phase;
	logic [15:0]     pix_held;
	logic [23:0]     last_color;
	bit              have_last;
	logic [2:0]      cnt_phase;
	logic [31:0]     cnt_acc;
	logic [FP_W-1:0] emitted;

	rgbrl_result_t pending_records_q[$];   // records the core still owes, oldest first
	byte_answer_t  answers_q[$];           // one entry per byte offered, in offer order

	bit calm;          // no idling on either side while set
	bit hold_out_req;  // ask the receiver for one long hold-off

	int mismatches;
	int records_checked;
	int frames_closed;
	int bytes_decoded;
	int bytes_sent;
	int cfg_writes;
	int stuck;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rgbrl_result_t rec(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [FP_W-1:0] run, input logic done,
			input logic inc);
		rgbrl_result_t res;
		res.red        = r;
		res.green      = g;
		res.blue       = b;
		res.run_length = run;
		res.frame_done = done;
		res.incomplete = inc;
		return res;
	endfunction

	function automatic table_row_t byte_row(input logic [7:0] data, input logic last);
		table_row_t row;
		row.kind    = ROW_BYTE;
		row.setting = '0;
		row.data    = data;
		row.last    = last;
		row.typed   = 1'b0;
		row.answer  = '0;
		return row;
	endfunction

	function automatic table_row_t checked_row(input logic [7:0] data, input logic last,
			input rgbrl_result_t answer);
		table_row_t row;
		row        = byte_row(data, last);
		row.typed  = 1'b1;
		row.answer = answer;
		return row;
	endfunction

	function automatic table_row_t cfg_row(input logic [FP_W-1:0] setting);
		table_row_t row;
		row         = byte_row(8'h00, 1'b0);
		row.kind    = ROW_CFG;
		row.setting = setting;
		return row;
	endfunction

	// Pixels still allowed in this frame; sizes above the maximum act as the maximum
	function automatic logic [FP_W-1:0] pixels_left();
		logic [FP_W-1:0] cap;
		cap = (fp_reg > MAX_PIX) ? MAX_PIX : fp_reg;
		return (emitted >= cap) ? '0 : cap - emitted;
	endfunction

	task automatic clear_frame();
		pix_phase  = BP_RED;
		pix_held   = '0;
		last_color = '0;
		have_last  = 1'b0;
		cnt_phase  = CP_NONE;
		cnt_acc    = '0;
		emitted    = '0;
	endtask

	// Advance the decoder model by one byte; got says whether a record comes out
	task automatic decode_byte(input logic [7:0] b, input logic last, output bit got,
			output bit used, output rgbrl_result_t res);
		logic [FP_W-1:0] left;
		logic [31:0]     run;
		logic [31:0]     total;
		logic [14:0]     v15;
		logic [23:0]     color;
		bit              counted;
		got     = 1'b0;
		res     = '0;
		counted = 1'b0;
		total   = '0;
		left    = pixels_left();
		used    = (left != 0);
		if (left == 0) begin
			// Frame full: drop the byte and forget any partial pixel or count
			pix_phase = BP_RED;
			cnt_phase = CP_NONE;
			cnt_acc   = '0;
		end else if (cnt_phase == CP_FIRST) begin
			if ((b & COUNT_EXT_BIT) != 0) begin
				cnt_acc   = {24'd0, b & COUNT_LOW_MASK};
				cnt_phase = CP_SECOND;
			end else begin
				counted = 1'b1;
				total   = {24'd0, b};
			end
		end else if (cnt_phase == CP_SECOND) begin
			v15 = {cnt_acc[6:0], b};
			if (v15 == COUNT_ESCAPE) begin
				cnt_acc   = '0;
				cnt_phase = CP_WORD0;
			end else begin
				counted = 1'b1;
				total   = {17'd0, v15};
			end
		end else if (cnt_phase >= CP_WORD0 && cnt_phase <= CP_WORD3) begin
			// Little-endian 32-bit count after the escape
			cnt_acc = cnt_acc | ({24'd0, b} << (8 * int'(cnt_phase - CP_WORD0)));
			if (cnt_phase == CP_WORD3) begin
				counted = 1'b1;
				total   = cnt_acc;
			end else
				cnt_phase = cnt_phase + 3'd1;
		end else begin
			cnt_phase = CP_NONE;
			case (pix_phase)
				BP_RED: begin
					pix_held  = {8'd0, b};
					pix_phase = BP_GREEN;
				end
				BP_GREEN: begin
					pix_held[15:8] = b;
					pix_phase      = BP_BLUE;
				end
				default: begin
					pix_phase = BP_RED;
					color     = {b, pix_held};
					pix_held  = '0;
					emitted   = emitted + 1'b1;
					got       = 1'b1;
					res       = rec(color[7:0], color[15:8], color[23:16], FP_W'(1), 1'b0,
						1'b0);
					// A repeated pixel announces a count, unless the frame just filled
					if (have_last && color == last_color && pixels_left() != 0) begin
						cnt_phase = CP_FIRST;
						cnt_acc   = '0;
					end
					last_color = color;
					have_last  = 1'b1;
				end
			endcase
		end
		if (counted) begin
			cnt_phase = CP_NONE;
			cnt_acc   = '0;
			// Counts of 0..2 repeat nothing; longer runs are cut to what the frame has left
			if (total > 32'd2) begin
				run  = total - 32'd2;
				left = pixels_left();
				if (run > {9'd0, left})
					run = {9'd0, left};
				if (run != 0) begin
					emitted = emitted + run[FP_W-1:0];
					got     = 1'b1;
					res     = rec(last_color[7:0], last_color[15:8], last_color[23:16],
						run[FP_W-1:0], 1'b0, 1'b0);
				end
			end
		end
		if (last) begin
			// The closing byte always answers; a bare marker carries zero color and run
			if (!got)
				res = '0;
			got            = 1'b1;
			res.frame_done = 1'b1;
			res.incomplete = (pix_phase != BP_RED) || (cnt_phase != CP_NONE);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (want !== seen) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, seen);
			mismatches++;
		end
	endtask

	// Offer one byte and hold it until the core takes it; returns on the falling edge
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input rgbrl_result_t answer);
		byte_answer_t a;
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		a.typed   = typed;
		a.answer  = answer;
		answers_q = {answers_q, a};
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering, wait for every owed record, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_records_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_frame_pixels(input logic [FP_W-1:0] setting);
		cfg_we    <= 1'b1;
		cfg_wdata <= setting;
		fp_reg     = setting;
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Scoreboard: retire results first, then predict from the byte taken on this edge
	always @(posedge clk) begin : scoreboard
		rgbrl_result_t seen;
		rgbrl_result_t want;
		rgbrl_result_t guess;
		byte_answer_t  a;
		bit            got;
		bit            used;
		bit            moved;
		moved = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			seen  = rec(red, green, blue, run_length, frame_done, incomplete);
			if (pending_records_q.size() == 0) begin
				$error("result with nothing pending: rgb %h %h %h run %0d done %b inc %b",
					red, green, blue, run_length, frame_done, incomplete);
				mismatches++;
			end else begin
				want = pending_records_q.pop_front();
				check_field("red", 32'(want.red), 32'(seen.red));
				check_field("green", 32'(want.green), 32'(seen.green));
				check_field("blue", 32'(want.blue), 32'(seen.blue));
				check_field("run_length", 32'(want.run_length), 32'(seen.run_length));
				check_field("frame_done", 32'(want.frame_done), 32'(seen.frame_done));
				check_field("incomplete", 32'(want.incomplete), 32'(seen.incomplete));
				records_checked++;
				if (want.frame_done)
					frames_closed++;
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
			a     = answers_q.pop_front();
			bytes_sent++;
			decode_byte(data_byte, frame_end, got, used, guess);
			if (used)
				bytes_decoded++;
			if (a.typed)
				pending_records_q = {pending_records_q, a.answer};
			else if (got)
				pending_records_q = {pending_records_q, guess};
		end
		stuck = moved ? 0 : stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d records owed", stuck,
				pending_records_q.size());
			$display("[rgb_run_length_pixel_decoder_core] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, a calm stretch, and one long hold-off counted here
	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_out_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				out_stall    <= 1'b0;
				hold_out_req  = 1'b0;
			end else
				out_stall <= !calm && ($urandom_range(99) < 12);
		end
	end

	initial begin : stimulus
		table_row_t      dir_q[$];
		logic [7:0]      frame_q[$];
		logic [23:0]     color;
		logic [23:0]     prev;
		logic [31:0]     cnt;
		logic [FP_W-1:0] setting;
		bit              have_prev;
		bit              mark_end;
		int              phase_no;
		int              n_frames;
		int              n_pix;
		int              sel;
		int              keep;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		data_byte    = '0;
		frame_end    = 1'b0;
		out_stall    = 1'b0;
		calm         = 1'b0;
		hold_out_req = 1'b0;
		mismatches   = 0;
		stuck        = 0;
		fp_reg       = FRAME_PIXELS_RST;
		clear_frame();
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, starting from the reset frame size
		// white pixel, then the same pixel again, which arms a count
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, checked_row(8'hFF, 1'b0,
			rec(8'hFF, 8'hFF, 8'hFF, FP_W'(1), 1'b0, 1'b0))};
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, checked_row(8'hFF, 1'b0,
			rec(8'hFF, 8'hFF, 8'hFF, FP_W'(1), 1'b0, 1'b0))};
		// count of two: no repeats, no record
		dir_q = {dir_q, byte_row(8'h02, 1'b0)};
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		dir_q = {dir_q, checked_row(8'hFF, 1'b0,
			rec(8'hFF, 8'hFF, 8'hFF, FP_W'(1), 1'b0, 1'b0))};
		// escape to a 32-bit count of all ones: run cut to the rest of the frame
		repeat (6)
			dir_q = {dir_q, byte_row(8'hFF, 1'b0)};
		// frame full: the end byte is dropped and a bare marker comes back
		dir_q = {dir_q, checked_row(8'h00, 1'b1,
			rec(8'h00, 8'h00, 8'h00, '0, 1'b1, 1'b0))};
		// oversized size acts as the maximum; end inside a pixel
		dir_q = {dir_q, cfg_row(FP_W'(23'h7FFFFF))};
		dir_q = {dir_q, byte_row(8'h01, 1'b0)};
		dir_q = {dir_q, checked_row(8'h02, 1'b1,
			rec(8'h00, 8'h00, 8'h00, '0, 1'b1, 1'b1))};
		// zero-pixel frame ignores everything
		dir_q = {dir_q, cfg_row('0)};
		dir_q = {dir_q, checked_row(8'h80, 1'b1,
			rec(8'h00, 8'h00, 8'h00, '0, 1'b1, 1'b0))};
		// one-pixel frame: the pixel fills it, closing on the same byte
		dir_q = {dir_q, cfg_row(FP_W'(1))};
		dir_q = {dir_q, byte_row(8'h00, 1'b0)};
		dir_q = {dir_q, byte_row(8'h80, 1'b0)};
		dir_q = {dir_q, checked_row(8'h7F, 1'b1,
			rec(8'h00, 8'h80, 8'h7F, FP_W'(1), 1'b1, 1'b0))};

		foreach (dir_q[i]) begin
			if (dir_q[i].kind == ROW_CFG) begin
				settle();
				write_frame_pixels(dir_q[i].setting);
			end else
				send_byte(dir_q[i].data, dir_q[i].last, dir_q[i].typed, dir_q[i].answer);
		end

		// Random part: phases of frames, each under a fresh frame size written while idle.
		// Frames left open across a phase boundary see the size change mid-frame.
		phase_no = 0;
		while (bytes_sent < TARGET_BYTES) begin
			sel = $urandom_range(99);
			if (sel < 55)
				setting = FP_W'($urandom_range(1, 40));
			else if (sel < 75)
				setting = FP_W'($urandom_range(41, 5000));
			else if (sel < 81)
				setting = '0;
			else if (sel < 87)
				setting = MAX_PIX;
			else if (sel < 93)
				setting = FP_W'($urandom_range(MAX_FRAME_PIXELS_DEF + 1, 23'h7FFFFF));
			else
				setting = FRAME_PIXELS_RST;
			if (phase_no == 2)
				setting = FRAME_PIXELS_RST;
			settle();
			write_frame_pixels(setting);
			calm     = (phase_no == 4);
			n_frames = calm ? 10 : $urandom_range(1, 4);
			if (phase_no == 2) begin
				hold_out_req = 1'b1;
				n_frames     = 6;
			end
			repeat (n_frames) begin
				frame_q.delete();
				have_prev = 1'b0;
				prev      = '0;
				n_pix     = $urandom_range(0, 10);
				for (int k = 0; k < n_pix; k++) begin
					if (have_prev && $urandom_range(99) < 40)
						color = prev;
					else begin
						color = 24'($urandom);
						if (have_prev && color == prev)
							color = color ^ 24'h1;
					end
					frame_q = {frame_q, color[7:0]};
					frame_q = {frame_q, color[15:8]};
					frame_q = {frame_q, color[23:16]};
					if (have_prev && color == prev) begin
						// repeated pixel: one-byte, two-byte or escaped 32-bit count
						sel = $urandom_range(99);
						if (sel < 55) begin
							cnt = ($urandom_range(9) == 0) ? $urandom_range(0, 127)
								: $urandom_range(0, 12);
							frame_q = {frame_q, cnt[7:0]};
						end else if (sel < 85) begin
							cnt = $urandom_range(0, 16'h7FFE);
							frame_q = {frame_q, {1'b1, cnt[14:8]}};
							frame_q = {frame_q, cnt[7:0]};
						end else begin
							cnt = $urandom_range(1) ? $urandom : $urandom_range(0, 60);
							frame_q = {frame_q, 8'hFF};
							frame_q = {frame_q, 8'hFF};
							frame_q = {frame_q, cnt[7:0]};
							frame_q = {frame_q, cnt[15:8]};
							frame_q = {frame_q, cnt[23:16]};
							frame_q = {frame_q, cnt[31:24]};
						end
					end
					prev      = color;
					have_prev = 1'b1;
					if ($urandom_range(99) < 4)
						frame_q = {frame_q, 8'($urandom_range(255))};
				end
				if (frame_q.size() == 0)
					frame_q = {frame_q, 8'($urandom_range(255))};
				// Mostly clean frames; some cut short inside a pixel or count, some left open
				sel      = $urandom_range(99);
				mark_end = (sel >= 12 && sel < 20) ? 1'b0 : 1'b1;
				if (sel < 12) begin
					keep = $urandom_range(1, frame_q.size());
					while (frame_q.size() > keep)
						frame_q.delete(frame_q.size() - 1);
				end
				foreach (frame_q[k])
					send_byte(frame_q[k], mark_end && (k == frame_q.size() - 1), 1'b0, '0);
			end
			calm = 1'b0;
			phase_no++;
		end

		settle();
		repeat (8)
			@(negedge clk);
		$display("Covered %0d bytes (%0d decoded) in %0d phases, %0d frame size settings;",
			bytes_sent, bytes_decoded, phase_no, cfg_writes);
		$display("checked %0d records, %0d of them frame closings.", records_checked,
			frames_closed);
		if (mismatches == 0)
			$display("[rgb_run_length_pixel_decoder_core] OK");
		else
			$display("[rgb_run_length_pixel_decoder_core] ERROR");
		$finish;
	end

endmodule

// ----- rgb_run_length_pixel_decoder_core.f -----
rtl/rgbrl_pkg.sv
rtl/rgbrl_decode.sv
rtl/rgbrl_out_queue.sv
rtl/rgb_run_length_pixel_decoder_core.sv
test/tb_rgb_run_length_pixel_decoder_core.sv
